>>> hdl/utf16_to_utf8_transcoder_core_macros.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH

// same-cycle implication
`define U16U8_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 to UTF-8 transcoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [15:0] MAX_1BYTE  = 16'h007F;
	localparam logic [15:0] MAX_2BYTE  = 16'h07FF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;

	// bytes for one code unit: up to four, bad marks error words
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [3:0]      bad;
		logic [1:0]      last_idx;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

>>> hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Classifies each code unit, pairs surrogates and builds its byte job.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front
	import u16u8_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [15:0] code_unit,
	input  wire logic        string_end,
	output logic             push,
	output job_t             job
);

	logic [9:0]      held_bits_q;
	logic            held_q;
	logic            is_high;
	logic            is_low;
	logic [3:0][7:0] norm_bytes;
	logic [3:0]      norm_bad;
	logic [2:0]      norm_cnt;
	logic [2:0]      cnt;
	logic [20:0]     cp;

	assign is_high = code_unit inside {[HIGH_FIRST:HIGH_LAST]};
	assign is_low  = code_unit inside {[LOW_FIRST:LOW_LAST]};
	assign cp      = {1'b0, held_bits_q, code_unit[9:0]} + SUPP_BASE;

	// unit handled as if nothing were held
	always_comb begin
		norm_bytes = '0;
		norm_bad   = '0;
		norm_cnt   = 3'd0;
		if (is_low) begin
			norm_bad[0] = 1'b1;
			norm_cnt    = 3'd1;
		end else if (is_high) begin
			if (string_end) begin
				norm_bad[0] = 1'b1;
				norm_cnt    = 3'd1;
			end
		end else if (code_unit <= MAX_1BYTE) begin
			norm_bytes[0] = {1'b0, code_unit[6:0]};
			norm_cnt      = 3'd1;
		end else if (code_unit <= MAX_2BYTE) begin
			norm_bytes[0] = LEAD_2 | {3'b000, code_unit[10:6]};
			norm_bytes[1] = CONT | {2'b00, code_unit[5:0]};
			norm_cnt      = 3'd2;
		end else begin
			norm_bytes[0] = LEAD_3 | {4'b0000, code_unit[15:12]};
			norm_bytes[1] = CONT | {2'b00, code_unit[11:6]};
			norm_bytes[2] = CONT | {2'b00, code_unit[5:0]};
			norm_cnt      = 3'd3;
		end
	end

	always_comb begin
		job = '0;
		cnt = norm_cnt;
		if (held_q && is_low) begin
			job.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
			job.bytes[1] = CONT | {2'b00, cp[17:12]};
			job.bytes[2] = CONT | {2'b00, cp[11:6]};
			job.bytes[3] = CONT | {2'b00, cp[5:0]};
			cnt          = 3'd4;
		end else if (held_q) begin
			// broken pair: error word first, then the unit itself
			job.bytes = {norm_bytes[2:0], 8'h00};
			job.bad   = {norm_bad[2:0], 1'b1};
			cnt       = norm_cnt + 3'd1;
		end else begin
			job.bytes = norm_bytes;
			job.bad   = norm_bad;
		end
		job.last_idx = 2'(cnt - 3'd1);
	end

	assign push = accept && (cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_q      <= is_high && !string_end && !(held_q && is_low);
			held_bits_q <= (is_high && !string_end) ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

`default_nettype wire

>>> hdl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue
	import u16u8_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_stat_t   stat
);

	job_t             slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == QCntW'(QDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head job one byte per cycle into the output register while m_axis is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back
	import u16u8_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire job_t    head,
	input  wire q_stat_t stat,
	output logic         pop,
	output logic         m_axis_tvalid,
	input  wire logic    m_axis_tready,
	output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
	output logic         m_axis_tlast,   // run_last
	output logic         m_axis_tuser    // [0] bad_sequence
);

	logic [1:0] idx_q;
	logic       emit;
	logic       at_end;

	assign emit   = !stat.empty && (!m_axis_tvalid || m_axis_tready);
	assign at_end = (idx_q == head.last_idx);
	assign pop    = emit && at_end;

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= head.bytes[idx_q];
			m_axis_tuser <= head.bad[idx_q];
			m_axis_tlast <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			idx_q         <= '0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
			idx_q         <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> hdl/utf16_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and errors.
// ----------------------------------------------------------------------------
//  channel   dir  tdata              tlast       tuser
//  s_axis    in   [15:0] code_unit   string_end  -
//  m_axis    out  [7:0]  out_byte    run_last    [0] bad_sequence
//
// A unit is taken when the job queue has room; its up to 4 bytes leave one per
// cycle while m_axis is not stalled, through the byte-wide output register.
// A held high surrogate is taken without queuing a job of its own.
// Reset clears the held surrogate, the queue and the output valid.
// The two-entry queue lets input and output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16_to_utf8_transcoder_core_macros.svh"

module utf16_to_utf8_transcoder_core
	import u16u8_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  wire logic        s_axis_tlast,   // string_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic             m_axis_tlast,   // run_last
	output logic             m_axis_tuser    // [0] bad_sequence
);

	logic    accept;
	logic    q_push;
	logic    q_pop;
	job_t    q_in;
	job_t    q_head;
	q_stat_t q_stat;

	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (s_axis_tdata),
		.string_end (s_axis_tlast),
		.push       (q_push),
		.job        (q_in)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.stat          (q_stat),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	`U16U8_ASSERT_SAME(a_bad_is_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'h00, "error word carries nonzero byte")
	`U16U8_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
	`U16U8_ASSERT_SAME(a_pop_nonempty, q_pop, !q_stat.empty, "job popped from empty queue")
	`U16U8_ASSERT_NEXT(a_emit_valid, !q_stat.empty && !m_axis_tvalid, m_axis_tvalid, "queued job not shown on output")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: utf16_to_utf8_transcoder_core
// Drives UTF-16 code units on s_axis and checks every UTF-8 word on m_axis
// against listed bytes or an in-bench transcoder: a directed table (code point
// range edges, surrogate pairs, lone and dangling surrogates), then random
// strings that are mostly well formed, mixed with broken surrogate sequences.
// The sender works in bursts and the receiver stalls on its own patterns.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import u16u8_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RAND_UNITS  = 380;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} utf8_word_t;

	typedef struct packed {
		logic [15:0] unit;
		logic        eos;
	} unit_item_t;

	// directed row: bytes and bad are listed first word in the top bits
	typedef struct packed {
		logic [15:0]     unit;
		logic            eos;
		logic            typed;
		logic [2:0]      n;
		logic [3:0][7:0] bytes;
		logic [3:0]      bad;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [15:0] code_unit
	logic        s_axis_tlast = 1'b0;  // string_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [7:0] out_byte
	logic        m_axis_tlast;         // run_last
	logic        m_axis_tuser;         // [0] bad_sequence

	utf8_word_t  utf8_expected[$];
	utf8_word_t  step_words[$];
	utf8_word_t  head_w;
	dir_row_t    dir_rows[$];

	// predictor copy of the held high surrogate
	logic        pend_valid = 1'b0;
	logic [9:0]  pend_bits = '0;

	int unsigned burst_left = 0;
	int unsigned cycles = 0;
	int unsigned failures = 0;
	int unsigned units_sent = 0;
	int unsigned words_checked = 0;
	int unsigned err_words = 0;
	int unsigned pairs_seen = 0;

	logic [1:0]  rx_mode = '0;
	int unsigned rx_left = 0;
	logic [15:0] rx_pattern = 16'h0001;

	utf16_to_utf8_transcoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic utf8_word_t mk_word(input logic [7:0] data, input logic bad);
		utf8_word_t w;
		w.data = data;
		w.last = 1'b0;
		w.bad  = bad;
		return w;
	endfunction

	function automatic void add_point(input logic [20:0] cp);
		if (cp <= {5'b0, MAX_1BYTE}) begin
			step_words.push_back(mk_word(cp[7:0], 1'b0));
		end else if (cp <= {5'b0, MAX_2BYTE}) begin
			step_words.push_back(mk_word(LEAD_2 | {3'b0, cp[10:6]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[5:0]}, 1'b0));
		end else if (cp < SUPP_BASE) begin
			step_words.push_back(mk_word(LEAD_3 | {4'b0, cp[15:12]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[11:6]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[5:0]}, 1'b0));
		end else begin
			step_words.push_back(mk_word(LEAD_4 | {5'b0, cp[20:18]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[17:12]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[11:6]}, 1'b0));
			step_words.push_back(mk_word(CONT | {2'b0, cp[5:0]}, 1'b0));
		end
	endfunction

	// words caused by one code unit, into step_words; updates the held surrogate
	function automatic void transcode_unit(input logic [15:0] u, input logic e);
		logic is_hi;
		logic is_lo;
		step_words.delete();
		is_hi = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
		is_lo = (u >= LOW_FIRST) && (u <= LOW_LAST);
		if (pend_valid && is_lo) begin
			add_point({1'b0, pend_bits, u[9:0]} + SUPP_BASE);
			pend_valid = 1'b0;
			pend_bits  = '0;
			pairs_seen++;
		end else begin
			// dangling high surrogate: error word, then the unit as usual
			if (pend_valid) begin
				step_words.push_back(mk_word(8'h00, 1'b1));
				pend_valid = 1'b0;
				pend_bits  = '0;
			end
			if (is_lo) begin
				step_words.push_back(mk_word(8'h00, 1'b1));
			end else if (is_hi) begin
				if (e) begin
					step_words.push_back(mk_word(8'h00, 1'b1));
				end else begin
					pend_bits  = u[9:0];
					pend_valid = 1'b1;
				end
			end else begin
				add_point({5'b0, u});
			end
		end
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last = 1'b1;
	endfunction

	function automatic dir_row_t typed_row(input logic [15:0] u, input logic e,
			input logic [2:0] n, input logic [31:0] bytes, input logic [3:0] bad);
		dir_row_t r;
		r.unit  = u;
		r.eos   = e;
		r.typed = 1'b1;
		r.n     = n;
		r.bytes = bytes;
		r.bad   = bad;
		return r;
	endfunction

	function automatic dir_row_t pred_row(input logic [15:0] u, input logic e);
		dir_row_t r;
		r = '0;
		r.unit = u;
		r.eos  = e;
		return r;
	endfunction

	// returns in the time step of the accepting edge
	task automatic send_unit(input logic [15:0] u, input logic e);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= u;
		s_axis_tlast  <= e;
		do @(posedge clk); while (!s_axis_tready);
		units_sent++;
	endtask

	task automatic send_and_predict(input logic [15:0] u, input logic e);
		send_unit(u, e);
		transcode_unit(u, e);
		foreach (step_words[k])
			utf8_expected.push_back(step_words[k]);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (utf8_expected.size() != 0)
			@(posedge clk);
	endtask

	// receiver: ready pattern switches between four modes, each held for a random run
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode    <= 2'($urandom_range(0, 3));
			rx_left    <= $urandom_range(16, 96);
			rx_pattern <= 16'($urandom) | 16'h0001;
		end else begin
			rx_left    <= rx_left - 1;
			rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
		end
		case (rx_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
			2'd2: m_axis_tready <= rx_pattern[0];
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycles, utf8_expected.size());
			$display("FAILURE");
			$finish;
		end else if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected word: out_byte %h run_last %b bad_sequence %b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				failures++;
			end else begin
				head_w = utf8_expected.pop_front();
				words_checked++;
				if (m_axis_tuser)
					err_words++;
				if (m_axis_tdata !== head_w.data) begin
					$error("out_byte: expected %h, got %h", head_w.data, m_axis_tdata);
					failures++;
				end
				if (m_axis_tlast !== head_w.last) begin
					$error("run_last: expected %b, got %b", head_w.last, m_axis_tlast);
					failures++;
				end
				if (m_axis_tuser !== head_w.bad) begin
					$error("bad_sequence: expected %b, got %b", head_w.bad, m_axis_tuser);
					failures++;
				end
			end
		end
	end

	initial begin
		unit_item_t  gen_units[$];
		int unsigned rand_sent;
		int unsigned len;
		int unsigned dir_count;
		logic [15:0] u;
		logic [15:0] v;
		utf8_word_t  w;

		// range edges of each byte length
		dir_rows.push_back(typed_row(16'h0000, 1'b0, 3'd1, 32'h00_00_00_00, 4'b0000));
		dir_rows.push_back(typed_row(16'h007F, 1'b0, 3'd1, 32'h7F_00_00_00, 4'b0000));
		dir_rows.push_back(typed_row(16'h0080, 1'b0, 3'd2, 32'hC2_80_00_00, 4'b0000));
		dir_rows.push_back(typed_row(16'h07FF, 1'b0, 3'd2, 32'hDF_BF_00_00, 4'b0000));
		dir_rows.push_back(typed_row(16'h0800, 1'b0, 3'd3, 32'hE0_A0_80_00, 4'b0000));
		dir_rows.push_back(typed_row(16'hFFFF, 1'b0, 3'd3, 32'hEF_BF_BF_00, 4'b0000));
		dir_rows.push_back(typed_row(16'hD7FF, 1'b0, 3'd3, 32'hED_9F_BF_00, 4'b0000));
		dir_rows.push_back(typed_row(16'hE000, 1'b0, 3'd3, 32'hEE_80_80_00, 4'b0000));
		// lone low surrogates
		dir_rows.push_back(typed_row(16'hDC00, 1'b0, 3'd1, 32'h0, 4'b1000));
		dir_rows.push_back(typed_row(16'hDFFF, 1'b0, 3'd1, 32'h0, 4'b1000));
		// pairs at both ends of the supplementary range
		dir_rows.push_back(typed_row(16'hD800, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(typed_row(16'hDC00, 1'b0, 3'd4, 32'hF0_90_80_80, 4'b0000));
		dir_rows.push_back(typed_row(16'hDBFF, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(typed_row(16'hDFFF, 1'b1, 3'd4, 32'hF4_8F_BF_BF, 4'b0000));
		// held high followed by a plain unit
		dir_rows.push_back(typed_row(16'hD800, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(typed_row(16'h0041, 1'b0, 3'd2, 32'h00_41_00_00, 4'b1000));
		// high after high: first reported as an error word, second held and then paired
		dir_rows.push_back(typed_row(16'hDBFF, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(typed_row(16'hDA00, 1'b0, 3'd1, 32'h0, 4'b1000));
		dir_rows.push_back(pred_row(16'hDC01, 1'b0));
		// high surrogate at the end of the string
		dir_rows.push_back(typed_row(16'hD834, 1'b1, 3'd1, 32'h0, 4'b1000));
		dir_rows.push_back(typed_row(16'hD800, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(typed_row(16'hD900, 1'b1, 3'd2, 32'h0, 4'b1100));
		dir_rows.push_back(typed_row(16'hD800, 1'b0, 3'd0, 32'h0, 4'b0000));
		dir_rows.push_back(pred_row(16'h20AC, 1'b1));
		dir_rows.push_back(typed_row(16'h0000, 1'b1, 3'd1, 32'h00_00_00_00, 4'b0000));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].typed) begin
				send_unit(dir_rows[i].unit, dir_rows[i].eos);
				transcode_unit(dir_rows[i].unit, dir_rows[i].eos);
				for (int k = 0; k < dir_rows[i].n; k++) begin
					w.data = dir_rows[i].bytes[3 - k];
					w.bad  = dir_rows[i].bad[3 - k];
					w.last = (k == dir_rows[i].n - 1);
					utf8_expected.push_back(w);
				end
			end else begin
				send_and_predict(dir_rows[i].unit, dir_rows[i].eos);
			end
		end
		dir_count = units_sent;
		// input held off until the output side is empty
		drain_results();

		rand_sent = 0;
		while (rand_sent < RAND_UNITS) begin
			gen_units.delete();
			if ($urandom_range(0, 99) < 85) begin
				// well-formed string of random characters
				len = $urandom_range(1, 10);
				repeat (len) begin
					case ($urandom_range(0, 3))
						0: gen_units.push_back(unit_item_t'{unit: 16'($urandom_range(0, 16'h7F)), eos: 1'b0});
						1: gen_units.push_back(unit_item_t'{unit: 16'($urandom_range(16'h80, 16'h7FF)), eos: 1'b0});
						2: begin
							u = 16'($urandom_range(16'h800, 16'hFFFF));
							if (u >= HIGH_FIRST && u <= LOW_LAST)
								u = u ^ 16'h2000;
							gen_units.push_back(unit_item_t'{unit: u, eos: 1'b0});
						end
						default: begin
							gen_units.push_back(unit_item_t'{unit: HIGH_FIRST + 16'($urandom_range(0, 1023)), eos: 1'b0});
							gen_units.push_back(unit_item_t'{unit: LOW_FIRST + 16'($urandom_range(0, 1023)), eos: 1'b0});
						end
					endcase
				end
				gen_units[gen_units.size() - 1].eos = 1'b1;
			end else begin
				u = HIGH_FIRST + 16'($urandom_range(0, 1023));
				case ($urandom_range(0, 4))
					0: gen_units.push_back(unit_item_t'{unit: LOW_FIRST + 16'($urandom_range(0, 1023)),
						eos: 1'($urandom_range(0, 1))});
					1: begin
						v = 16'($urandom);
						if (v >= LOW_FIRST && v <= LOW_LAST)
							v = v ^ 16'h0400;
						gen_units.push_back(unit_item_t'{unit: u, eos: 1'b0});
						gen_units.push_back(unit_item_t'{unit: v, eos: 1'($urandom_range(0, 1))});
					end
					2: gen_units.push_back(unit_item_t'{unit: u, eos: 1'b1});
					3: gen_units.push_back(unit_item_t'{unit: 16'($urandom), eos: 1'($urandom_range(0, 1))});
					default: begin
						gen_units.push_back(unit_item_t'{unit: u, eos: 1'b0});
						gen_units.push_back(unit_item_t'{unit: HIGH_FIRST + 16'($urandom_range(0, 1023)), eos: 1'b0});
						gen_units.push_back(unit_item_t'{unit: LOW_FIRST + 16'($urandom_range(0, 1023)), eos: 1'b1});
					end
				endcase
			end
			foreach (gen_units[k])
				send_and_predict(gen_units[k].unit, gen_units[k].eos);
			rand_sent += gen_units.size();
			if ($urandom_range(0, 15) == 0)
				drain_results();
		end

		drain_results();
		repeat (20) @(posedge clk);

		$display("%0d code units (%0d directed), %0d surrogate pairs; %0d words checked, %0d error words",
			units_sent, dir_count, pairs_seen, words_checked, err_words);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
